/* hdl/lis_pkg.sv */
package lis_pkg;

    localparam int unsigned SlotCount = 9;
    localparam int unsigned SlotWidth = 4;

    localparam logic [6:0] OPC_LUI  = 7'h37;
    localparam logic [6:0] OPC_IMM  = 7'h13;
    localparam logic [6:0] OPC_JALR = 7'h67;
    localparam logic [2:0] F3_ADDI  = 3'h0;
    localparam logic [2:0] F3_SLLI  = 3'h1;
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;
    localparam logic [4:0] REG_T0   = 5'd5;
    localparam logic [11:0] PREAMBLE_IMM = 12'hfd0;
    localparam logic [11:0] SHAMT_11 = 12'd11;
    localparam logic [11:0] SHAMT_10 = 12'd10;

    typedef enum logic [1:0] {
        FUNC_LI   = 2'd0,
        FUNC_CALL = 2'd1,
        FUNC_PRE  = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CLS_SMALL,
        CLS_MID,
        CLS_BIG
    } cls_t;

    typedef enum logic [SlotWidth-1:0] {
        SLOT_HEAD  = 4'd0,
        SLOT_ADD0  = 4'd1,
        SLOT_SHL0  = 4'd2,
        SLOT_ADD1  = 4'd3,
        SLOT_SHL1  = 4'd4,
        SLOT_ADD2  = 4'd5,
        SLOT_SHL2  = 4'd6,
        SLOT_ADD3  = 4'd7,
        SLOT_JUMP  = 4'd8
    } slot_t;

    function automatic logic [31:0] enc_u(logic [19:0] imm20, logic [4:0] rd,
                                          logic [6:0] op);
        return {imm20, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm12, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd,
                                          logic [6:0] op);
        return {imm12, rs1, f3, rd, op};
    endfunction

endpackage

/* hdl/lis_word_gen.sv */
module lis_word_gen
(
    input  lis_pkg::func_t      func,
    input  lis_pkg::cls_t       cls,
    input  logic [63:0]         value,
    input  logic [4:0]          rd,
    input  lis_pkg::slot_t      slot,
    output logic [31:0]         word
);
    import lis_pkg::*;

    logic [19:0] hi_mid;
    logic [19:0] hi_big;
    logic [11:0] add0_imm;

    // carry into LUI for the sign-extended ADDI that follows
    assign hi_mid   = value[31:12] + {19'd0, value[11]};
    assign hi_big   = value[63:44] + {19'd0, value[43]};
    assign add0_imm = (cls == CLS_MID) ? value[11:0] : value[43:32];

    always_comb
    begin
        word = '0;
        unique case (slot)
            SLOT_HEAD:
            begin
                if (func == FUNC_PRE)
                begin
                    word = enc_i(PREAMBLE_IMM, REG_SP, F3_ADDI, REG_SP, OPC_IMM);
                end
                else
                begin
                    unique case (cls)
                        CLS_SMALL: word = enc_i(value[11:0], REG_ZERO, F3_ADDI, rd, OPC_IMM);
                        CLS_MID:   word = enc_u(hi_mid, rd, OPC_LUI);
                        CLS_BIG:   word = enc_u(hi_big, rd, OPC_LUI);
                        default:   word = '0;
                    endcase
                end
            end
            SLOT_ADD0: word = enc_i(add0_imm, rd, F3_ADDI, rd, OPC_IMM);
            SLOT_SHL0: word = enc_i(SHAMT_11, rd, F3_SLLI, rd, OPC_IMM);
            SLOT_ADD1: word = enc_i({1'b0, value[31:21]}, rd, F3_ADDI, rd, OPC_IMM);
            SLOT_SHL1: word = enc_i(SHAMT_11, rd, F3_SLLI, rd, OPC_IMM);
            SLOT_ADD2: word = enc_i({1'b0, value[20:10]}, rd, F3_ADDI, rd, OPC_IMM);
            SLOT_SHL2: word = enc_i(SHAMT_10, rd, F3_SLLI, rd, OPC_IMM);
            SLOT_ADD3: word = enc_i({2'b00, value[9:0]}, rd, F3_ADDI, rd, OPC_IMM);
            SLOT_JUMP: word = enc_i(12'd0, REG_T0, F3_ADDI, REG_RA, OPC_JALR);
            default:   word = '0;
        endcase
    end

endmodule

/* hdl/riscv_immediate_load_sequencer_top.sv */
// RV64 load-immediate sequencer.
// Input channel: in_valid/in_stall with func, value, dest_reg. One word is an
// operation: load immediate into dest_reg, call via t0, or stack preamble.
// Output channel: out_valid/out_stall with insn_word and last; each item gives
// 1 to 9 instruction words, last marks the final one. func 3 gives none.
// The first word of an item goes from the item register to the output register
// and is presented from there once the item has been accepted.
// Throughput: one output word per cycle while out_stall is low. The next item is
// taken in the same cycle as the final word of the current one moves to the
// output register, so items flow back to back without gaps.
// When out_stall is high with out_valid set, the output register holds its word,
// the sequencer waits, and in_stall rises once the item register is occupied.
// Reset (rst_n low, asynchronous) empties the item and output registers.
module riscv_immediate_load_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [63:0] value,
    input  logic [4:0]  dest_reg,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] insn_word,
    output logic        last
);
    import lis_pkg::*;

    logic [SlotCount-1:0] pend_reg;
    logic [SlotCount-1:0] pend_next;
    func_t                func_reg;
    cls_t                 cls_reg;
    logic [63:0]          value_reg;
    logic [4:0]           rd_reg;

    logic                 out_valid_reg;
    logic [31:0]          word_reg;
    logic                 last_reg;

    logic                 out_load;
    logic                 advance;
    logic                 final_word;
    logic                 accept;
    logic [SlotCount-1:0] sel;
    slot_t                slot;
    logic [31:0]          word;

    func_t                in_func;
    cls_t                 in_cls;
    logic [SlotCount-1:0] in_mask;

    // input decode
    always_comb
    begin
        in_func = func_t'(func);
        if ((&value[63:11]) || !(|value[63:11]))
        begin
            in_cls = CLS_SMALL;
        end
        else if ((&value[63:31]) || !(|value[63:31]))
        begin
            in_cls = CLS_MID;
        end
        else
        begin
            in_cls = CLS_BIG;
        end

        in_mask = '0;
        unique case (in_func)
            FUNC_LI, FUNC_CALL:
            begin
                unique case (in_cls)
                    CLS_SMALL: in_mask[SLOT_HEAD] = 1'b1;
                    CLS_MID:
                    begin
                        in_mask[SLOT_HEAD] = 1'b1;
                        in_mask[SLOT_ADD0] = 1'b1;
                    end
                    CLS_BIG:
                    begin
                        in_mask[SLOT_HEAD] = 1'b1;
                        in_mask[SLOT_ADD0] = |value[43:32];
                        in_mask[SLOT_SHL0] = 1'b1;
                        in_mask[SLOT_ADD1] = |value[31:21];
                        in_mask[SLOT_SHL1] = 1'b1;
                        in_mask[SLOT_ADD2] = |value[20:10];
                        in_mask[SLOT_SHL2] = 1'b1;
                        in_mask[SLOT_ADD3] = |value[9:0];
                    end
                    default: in_mask = '0;
                endcase
                in_mask[SLOT_JUMP] = (in_func == FUNC_CALL);
            end
            FUNC_PRE:  in_mask[SLOT_HEAD] = 1'b1;
            FUNC_NONE: in_mask = '0;
            default:   in_mask = '0;
        endcase
    end

    // lowest pending slot
    assign sel = pend_reg & (~pend_reg + {{(SlotCount-1){1'b0}}, 1'b1});

    always_comb
    begin
        slot = SLOT_HEAD;
        for (int i = 0; i < SlotCount; i++)
        begin
            if (sel[i])
            begin
                slot = slot_t'(i[SlotWidth-1:0]);
            end
        end
    end

    lis_word_gen u_word_gen
    (
        .func  (func_reg),
        .cls   (cls_reg),
        .value (value_reg),
        .rd    ((func_reg == FUNC_CALL) ? REG_T0 : rd_reg),
        .slot  (slot),
        .word  (word)
    );

    assign out_load   = !out_valid_reg || !out_stall;
    assign advance    = (|pend_reg) && out_load;
    assign final_word = !(|(pend_reg & ~sel));
    assign in_stall   = (|pend_reg) && !(advance && final_word);
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (advance)
        begin
            pend_next = pend_reg & ~sel;
        end
        if (accept)
        begin
            pend_next = in_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_load)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= in_func;
            cls_reg   <= in_cls;
            value_reg <= value;
            rd_reg    <= dest_reg;
        end
        if (advance)
        begin
            word_reg <= word;
            last_reg <= final_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign insn_word = word_reg;
    assign last      = last_reg;

endmodule
